[sv/apmac_pkg.sv]
// apmac_pkg: shared types, constants and AES / GF(2^128) functions for the PMAC tag engine
`timescale 1ns / 1ps
package apmac_pkg;

  // default block counter width
  localparam int COUNT_WIDTH_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE = 3'd4;

  // key size codes
  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  // round key store: one 128-bit entry per round
  localparam int RK_DEPTH = 16;
  localparam int RK_AW = 4;

  // field polynomial constants
  localparam logic [7:0] POLY_MUL = 8'h87;
  localparam logic [7:0] POLY_DIV = 8'h43;
  localparam logic [7:0] TOP_BIT = 8'h80;

  typedef struct packed {
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [4:0]  valid_bytes;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] tag_hi;
    logic [63:0] tag_lo;
  } out_item_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_BLOCK,
    SRC_SUM
  } enc_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY_EXP,
    ST_L_START,
    ST_L_ENC,
    ST_L_SAVE,
    ST_DBL_START,
    ST_DBL,
    ST_MSG_START,
    ST_MSG_ENC,
    ST_MSG_SAVE,
    ST_LAST_START,
    ST_LAST_GO,
    ST_LAST_ENC,
    ST_TAG_OUT
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     kexp_start;
    logic     enc_start;
    enc_src_t enc_src;
    logic     l_load;
    logic     dbl_start;
    logic     off_update;
    logic     sum_acc;
    logic     last_fold;
    logic     tag_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kexp_done;
    logic enc_done;
    logic dbl_done;
    logic item_last;
  } dp_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // s-box on each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // one AES round without the round key; mix columns skipped in the final round
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    // sub bytes and shift rows
    for (int i = 0; i < 16; i++) begin
      t[i] = SBOX[b[4'((i % 4) + 4 * (((i / 4) + (i % 4)) % 4))]];
    end
    // mix columns
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r;
  endfunction

  // multiply by x in GF(2^128)
  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? POLY_MUL : 8'h00)};
  endfunction

  // multiply by x^-1 in GF(2^128)
  function automatic logic [127:0] gf_halve(input logic [127:0] v);
    return {1'b0, v[127:1]} ^ (v[0] ? {TOP_BIT, 112'd0, POLY_DIV} : 128'd0);
  endfunction

  // final block: full block takes L*x^-1, short block takes 10* padding
  function automatic logic [127:0] last_block_value(input logic [127:0] d,
                                                    input logic [4:0] vb,
                                                    input logic [127:0] l);
    logic [127:0] r;
    if (vb[4]) begin
      r = d ^ gf_halve(l);
    end else begin
      for (int b = 0; b < 16; b++) begin
        if (5'(b) < vb) r[127-8*b -: 8] = d[127-8*b -: 8];
        else if (5'(b) == vb) r[127-8*b -: 8] = TOP_BIT;
        else r[127-8*b -: 8] = 8'h00;
      end
    end
    return r;
  endfunction

endpackage

[sv/apmac_chan_if.sv]
// apmac_chan_if: valid/ready channel carrying one request payload
`timescale 1ns / 1ps
interface apmac_chan_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/apmac_ram.sv]
// apmac_ram: generic single write port, single read port RAM with registered read
`timescale 1ns / 1ps
module apmac_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/apmac_ctrl.sv]
// apmac_ctrl: sequencing state machine for key setup, block processing and tag output
`timescale 1ns / 1ps
module apmac_ctrl import apmac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;
  logic   in_message;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);
  assign in_ready = (state == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // message flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.l_load) begin
        in_message <= 1'b1;
      end else if (cmd.tag_load) begin
        in_message <= 1'b0;
      end
      if (cmd.tag_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!in_message) state_next = ST_KEY_EXP;
          else if (in_last) state_next = ST_LAST_START;
          else state_next = ST_DBL_START;
        end
      end
      ST_KEY_EXP:    if (status.kexp_done) state_next = ST_L_START;
      ST_L_START:    state_next = ST_L_ENC;
      ST_L_ENC:      if (status.enc_done) state_next = ST_L_SAVE;
      ST_L_SAVE:     state_next = status.item_last ? ST_LAST_START : ST_DBL_START;
      ST_DBL_START:  state_next = ST_DBL;
      ST_DBL:        if (status.dbl_done) state_next = ST_MSG_START;
      ST_MSG_START:  state_next = ST_MSG_ENC;
      ST_MSG_ENC:    if (status.enc_done) state_next = ST_MSG_SAVE;
      ST_MSG_SAVE:   state_next = ST_IDLE;
      ST_LAST_START: state_next = ST_LAST_GO;
      ST_LAST_GO:    state_next = ST_LAST_ENC;
      ST_LAST_ENC:   if (status.enc_done) state_next = ST_TAG_OUT;
      ST_TAG_OUT:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.enc_src = SRC_ZERO;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = accept;
        cmd.kexp_start = accept && !in_message;
      end
      ST_L_START: begin
        cmd.enc_start = 1'b1;
        cmd.enc_src = SRC_ZERO;
      end
      ST_L_SAVE:     cmd.l_load = 1'b1;
      ST_DBL_START:  cmd.dbl_start = 1'b1;
      ST_DBL:        cmd.off_update = status.dbl_done;
      ST_MSG_START: begin
        cmd.enc_start = 1'b1;
        cmd.enc_src = SRC_BLOCK;
      end
      ST_MSG_SAVE:   cmd.sum_acc = 1'b1;
      ST_LAST_START: cmd.last_fold = 1'b1;
      ST_LAST_GO: begin
        cmd.enc_start = 1'b1;
        cmd.enc_src = SRC_SUM;
      end
      ST_TAG_OUT:    cmd.tag_load = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  // a new tag never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.tag_load |-> (!out_valid || out_ready))
    else $error("tag loaded while output busy");

  // delivering a tag ends the message
  assert property (@(posedge clk) disable iff (rst)
    cmd.tag_load |=> (out_valid && !in_message && state == ST_IDLE))
    else $error("tag not presented or message not closed");

endmodule

[sv/apmac_dp.sv]
// apmac_dp: key registers, key expansion, round-iterative AES and PMAC offset/checksum state
`timescale 1ns / 1ps
module apmac_dp import apmac_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_item,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  output logic [127:0]          tag
);

  // configuration registers
  logic [63:0] key_word0, key_word1, key_word2, key_word3;
  logic [1:0]  key_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0 <= '0;
      key_word1 <= '0;
      key_word2 <= '0;
      key_word3 <= '0;
      key_size <= KS_128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_WORD0: key_word0 <= cfg_data;
        CFG_KEY_WORD1: key_word1 <= cfg_data;
        CFG_KEY_WORD2: key_word2 <= cfg_data;
        CFG_KEY_WORD3: key_word3 <= cfg_data;
        CFG_KEY_SIZE:  key_size <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // key as 32-bit words
  logic [31:0] kwords [8];
  assign kwords[0] = key_word0[63:32];
  assign kwords[1] = key_word0[31:0];
  assign kwords[2] = key_word1[63:32];
  assign kwords[3] = key_word1[31:0];
  assign kwords[4] = key_word2[63:32];
  assign kwords[5] = key_word2[31:0];
  assign kwords[6] = key_word3[63:32];
  assign kwords[7] = key_word3[31:0];

  // key length decode
  logic [3:0] nk_sel;
  always_comb begin
    unique case (key_size)
      KS_128:  nk_sel = 4'd4;
      KS_192:  nk_sel = 4'd6;
      default: nk_sel = 4'd8;
    endcase
  end

  // key expansion state
  logic        kexp_busy;
  logic [5:0]  wi;
  logic [2:0]  wmod;
  logic [7:0]  rcon;
  logic [3:0]  nk;
  logic [3:0]  nr;
  logic [31:0] win [8];
  logic [95:0] grp;
  logic [31:0] word, tw;
  logic [2:0]  nk_m1;
  logic        kexp_last;

  assign nk_m1 = 3'(nk - 4'd1);
  assign kexp_last = kexp_busy && (wi == {nr, 2'b11});

  // next expanded word
  always_comb begin
    if (wmod == 3'd0) begin
      tw = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'd0};
    end else if (nk == 4'd8 && wmod == 3'd4) begin
      tw = sub_word(win[0]);
    end else begin
      tw = win[0];
    end
    if (wi < {2'b00, nk}) word = kwords[wi[2:0]];
    else word = win[nk_m1] ^ tw;
  end

  // key expansion sequencer, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      kexp_busy <= 1'b0;
    end else if (cmd.kexp_start) begin
      kexp_busy <= 1'b1;
    end else if (kexp_last) begin
      kexp_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kexp_start) begin
      wi <= '0;
      wmod <= '0;
      rcon <= 8'h01;
      nk <= nk_sel;
      nr <= nk_sel + 4'd6;
    end else if (kexp_busy) begin
      wi <= wi + 6'd1;
      wmod <= (wmod == nk_m1) ? 3'd0 : wmod + 3'd1;
      if (wi >= {2'b00, nk} && wmod == 3'd0) begin
        rcon <= xt(rcon);
      end
      win[0] <= word;
      for (int k = 1; k < 8; k++) win[k] <= win[k-1];
      grp <= {grp[63:0], word};
    end
  end

  // round key store
  logic             rk_we;
  logic [RK_AW-1:0] rk_raddr;
  logic [127:0]     rk;

  assign rk_we = kexp_busy && (wi[1:0] == 2'b11);

  apmac_ram #(
    .WIDTH (128),
    .DEPTH (RK_DEPTH)
  ) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (wi[5:2]),
    .wdata ({grp, word}),
    .raddr (rk_raddr),
    .rdata (rk)
  );

  // message state
  in_item_t               item;
  logic [127:0]           l_val, offset, sum, lx;
  logic [COUNT_WIDTH-1:0] counter, cnt_inc, copy;
  logic [127:0]           item_data;

  assign item_data = {item.data_hi, item.data_lo};
  assign cnt_inc = counter + COUNT_WIDTH'(1);

  // AES engine, one round per cycle
  logic             enc_busy;
  logic [RK_AW-1:0] round;
  logic [127:0]     aes_st, enc_src_val;
  logic             enc_last;

  assign enc_last = enc_busy && (round == nr);
  assign rk_raddr = cmd.enc_start ? '0 : round + RK_AW'(1);

  always_comb begin
    case (cmd.enc_src)
      SRC_BLOCK: enc_src_val = item_data ^ offset;
      SRC_SUM:   enc_src_val = sum;
      default:   enc_src_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_busy <= 1'b0;
    end else if (cmd.enc_start) begin
      enc_busy <= 1'b1;
    end else if (enc_last) begin
      enc_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enc_start) begin
      aes_st <= enc_src_val;
      round <= '0;
    end else if (enc_busy) begin
      if (round == '0) aes_st <= aes_st ^ rk;
      else aes_st <= aes_round(aes_st, round == nr) ^ rk;
      round <= round + RK_AW'(1);
    end
  end

  // offset doubling: shift the count right until its lowest set bit,
  // a zero count runs the full width
  always_ff @(posedge clk) begin
    if (rst) begin
      copy <= COUNT_WIDTH'(1);
    end else if (cmd.dbl_start) begin
      copy <= cnt_inc;
    end else if (!copy[0]) begin
      copy <= {1'b1, copy[COUNT_WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dbl_start) begin
      lx <= l_val;
    end else if (!copy[0]) begin
      lx <= gf_double(lx);
    end
  end

  // item, L, offset, counter and checksum
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_item;
    if (cmd.l_load) begin
      l_val <= aes_st;
      offset <= '0;
      sum <= '0;
      counter <= '0;
    end else begin
      if (cmd.dbl_start) counter <= cnt_inc;
      if (cmd.off_update) offset <= offset ^ lx;
      if (cmd.sum_acc) sum <= sum ^ aes_st;
      else if (cmd.last_fold) sum <= sum ^ last_block_value(item_data, item.valid_bytes, l_val);
    end
    if (cmd.tag_load) tag <= aes_st;
  end

  assign status.kexp_done = kexp_last;
  assign status.enc_done = enc_last;
  assign status.dbl_done = copy[0];
  assign status.item_last = item.last_block;

  // the AES engine only starts when idle and after key setup
  assert property (@(posedge clk) disable iff (rst)
    cmd.enc_start |-> (!enc_busy && !kexp_busy))
    else $error("encryption started while busy");

  // key expansion and encryption never overlap
  assert property (@(posedge clk) disable iff (rst)
    !(kexp_busy && enc_busy))
    else $error("key expansion overlaps encryption");

  // results are taken only once the engine has finished
  assert property (@(posedge clk) disable iff (rst)
    (cmd.l_load || cmd.sum_acc || cmd.tag_load) |-> !enc_busy)
    else $error("engine output used while running");

endmodule

[sv/aes_pmac_tag_engine.sv]
// aes_pmac_tag_engine: PMAC1 tag engine over AES-128/192/256, top level
// Message blocks arrive one request at a time on in_ch; a tag request leaves on out_ch
// after each block marked last. The first block of a message first expands the key
// (one key word per cycle) and computes L = E_K(0) with 10, 12 or 14 rounds. A non-last
// block then takes one GF(2^128) doubling per cycle for the offset, then one AES round
// per cycle in the shared round unit. A last block is folded into the checksum, which
// is then encrypted for the tag. The block waiting for its tag to be taken does not
// stop the next block from entering. Key registers are read at message start, so
// write them between messages.
`timescale 1ns / 1ps
module aes_pmac_tag_engine import apmac_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  apmac_chan_if.sink            in_ch,
  apmac_chan_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t    cmd;
  dp_status_t   status;
  logic [127:0] tag;
  in_item_t     in_item;

  assign in_item = in_ch.data;

  // controller
  apmac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_item.last_block),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  apmac_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .tag       (tag)
  );

  // tag output
  assign out_ch.data = '{tag_hi: tag[127:64], tag_lo: tag[63:0]};

endmodule
